### sv/tihg_pkg.sv
// Shared constants, types and rounding helpers for the tricubic Hermite core.
package tihg_pkg;

  localparam int WFRAC = 30;
  localparam int COORD_FRAC_BITS = 16;
  localparam int TSHIFT = WFRAC - COORD_FRAC_BITS;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef logic [30:0]        tq_t;
  typedef logic signed [32:0] fac_t;
  typedef logic signed [35:0] wgt_t;
  typedef logic signed [39:0] term_t;
  typedef logic signed [47:0] acc_t;

  function automatic logic signed [71:0] rnd_q(input logic signed [71:0] p);
    rnd_q = (p + (72'sd1 <<< (WFRAC - 1))) >>> WFRAC;
  endfunction

  function automatic tq_t rnd_u(input logic [61:0] p);
    logic [61:0] s;
    s = (p + (62'd1 << (WFRAC - 1))) >> WFRAC;
    rnd_u = s[30:0];
  endfunction

endpackage

### sv/tricubic_hermite_interp_grad_core.sv
// Top level: pipelined tricubic Hermite interpolant with gradient.
// One transaction enters per cycle while the output is not stalled; a load writes one
// coefficient word, an evaluation returns the value and the three partial derivatives,
// each saturated to 32 bits. The depth is set by the four chained rounded multiplications
// for the axis powers and weights, the basis polynomials, the coefficient multiply and
// a two-level adder tree; the whole pipeline holds when the output is not taken.
module tricubic_hermite_interp_grad_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [4:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic [16:0]        pos_x,
  input  logic [16:0]        pos_y,
  input  logic [16:0]        pos_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_eval,
  output logic signed [31:0] interp_value,
  output logic signed [31:0] deriv_x,
  output logic signed [31:0] deriv_y,
  output logic signed [31:0] deriv_z
);

  localparam logic [16:0] ONE_C = 17'd1 << tihg_pkg::COORD_FRAC_BITS;
  localparam logic signed [35:0] ONE_W = 36'sd1 <<< tihg_pkg::WFRAC;

  logic adv;
  logic [9:1] v;
  logic [9:1] cm;

  logic signed [31:0] store [32];
  logic [4:0]  idx1, idx2, idx3, idx4, idx5, idx6;
  logic signed [31:0] val1, val2, val3, val4, val5, val6;

  tihg_pkg::tq_t t1 [3];
  tihg_pkg::tq_t t2a [3];
  tihg_pkg::tq_t t2b [3];
  tihg_pkg::tq_t t3a [3];
  tihg_pkg::tq_t t3b [3];
  tihg_pkg::tq_t t3c [3];
  tihg_pkg::fac_t bas4 [3][8];
  tihg_pkg::wgt_t xy5 [64];
  tihg_pkg::fac_t zf5 [8];
  tihg_pkg::wgt_t w6 [128];
  tihg_pkg::term_t term7 [128];
  tihg_pkg::acc_t part8 [4][4];
  tihg_pkg::acc_t part_next [4][4];
  logic signed [31:0] res9 [4];
  logic signed [31:0] res_next [4];

  logic [16:0] pos_in [3];

  assign adv = !v[9] || out_ready;
  assign in_ready = adv;
  assign pos_in[0] = pos_x;
  assign pos_in[1] = pos_y;
  assign pos_in[2] = pos_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[8:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < 32; e++) begin
        store[e] <= '0;
      end
    end else if (adv && v[6] && cm[6] == tihg_pkg::CMD_LOAD) begin
      store[idx6] <= val6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cm <= {cm[8:1], cmd};
      idx1 <= coef_index;
      idx2 <= idx1;
      idx3 <= idx2;
      idx4 <= idx3;
      idx5 <= idx4;
      idx6 <= idx5;
      val1 <= coef_value;
      val2 <= val1;
      val3 <= val2;
      val4 <= val3;
      val5 <= val4;
      val6 <= val5;
      for (int a = 0; a < 3; a++) begin
        t1[a] <= tihg_pkg::tq_t'(((pos_in[a] > ONE_C) ? ONE_C : pos_in[a])) << tihg_pkg::TSHIFT;
        t2a[a] <= tihg_pkg::rnd_u(62'(t1[a]) * 62'(t1[a]));
        t2b[a] <= t1[a];
        t3a[a] <= tihg_pkg::rnd_u(62'(t2a[a]) * 62'(t2b[a]));
        t3b[a] <= t2a[a];
        t3c[a] <= t2b[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [35:0] tt, s2, s3;
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        tt = $signed({5'b0, t3c[a]});
        s2 = $signed({5'b0, t3b[a]});
        s3 = $signed({5'b0, t3a[a]});
        bas4[a][0] <= 33'(ONE_W - 3 * s2 + 2 * s3);
        bas4[a][1] <= 33'(3 * s2 - 2 * s3);
        bas4[a][2] <= 33'(tt - 2 * s2 + s3);
        bas4[a][3] <= 33'(s3 - s2);
        bas4[a][4] <= 33'(6 * s2 - 6 * tt);
        bas4[a][5] <= 33'(6 * tt - 6 * s2);
        bas4[a][6] <= 33'(3 * s2 - 4 * tt + ONE_W);
        bas4[a][7] <= 33'(3 * s2 - 2 * tt);
      end
      for (int p = 0; p < 64; p++) begin
        xy5[p] <= 36'(tihg_pkg::rnd_q(72'(bas4[0][p / 8]) * 72'(bas4[1][p % 8])));
      end
      for (int k = 0; k < 8; k++) begin
        zf5[k] <= bas4[2][k];
      end
    end
  end

  for (genvar q = 0; q < 4; q++) begin : g_q
    for (genvar m = 0; m < 8; m++) begin : g_m
      for (genvar c = 0; c < 4; c++) begin : g_c
        localparam int TI = q * 32 + m * 4 + c;
        localparam int XI = ((q == 1) ? 4 : 0) + ((c == 1) ? 2 : 0) + ((m / 4) % 2);
        localparam int YI = ((q == 2) ? 4 : 0) + ((c == 2) ? 2 : 0) + ((m / 2) % 2);
        localparam int ZI = ((q == 3) ? 4 : 0) + ((c == 3) ? 2 : 0) + (m % 2);
        localparam int CI = (c == 0) ? m : 8 + 3 * m + c - 1;
        always_ff @(posedge clk) begin
          if (adv) begin
            w6[TI] <= 36'(tihg_pkg::rnd_q(72'(xy5[XI * 8 + YI]) * 72'(zf5[ZI])));
            term7[TI] <= 40'(tihg_pkg::rnd_q(72'(store[CI]) * 72'(w6[TI])));
          end
        end
      end
    end
  end

  always_comb begin
    for (int q = 0; q < 4; q++) begin
      for (int g = 0; g < 4; g++) begin
        part_next[q][g] = '0;
        for (int k = 0; k < 8; k++) begin
          part_next[q][g] = part_next[q][g] + 48'(term7[q * 32 + g * 8 + k]);
        end
      end
    end
  end

  always_comb begin
    tihg_pkg::acc_t s;
    for (int q = 0; q < 4; q++) begin
      s = part8[q][0] + part8[q][1] + part8[q][2] + part8[q][3];
      if (cm[8] != tihg_pkg::CMD_EVAL) begin
        res_next[q] = '0;
      end else if (s > 48'sh0000_7FFF_FFFF) begin
        res_next[q] = 32'sh7FFF_FFFF;
      end else if (s < -48'sh0000_8000_0000) begin
        res_next[q] = 32'sh8000_0000;
      end else begin
        res_next[q] = s[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      part8 <= part_next;
      res9 <= res_next;
    end
  end

  assign out_valid = v[9];
  assign is_eval = cm[9];
  assign interp_value = res9[0];
  assign deriv_x = res9[1];
  assign deriv_y = res9[2];
  assign deriv_z = res9[3];

  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_eval |-> interp_value == 0 && deriv_x == 0 && deriv_y == 0 && deriv_z == 0)
    else $error("load acknowledge carries a non-zero result");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_store_clear: assert property (@(posedge clk) rst |=> store[0] == 0 && store[31] == 0)
    else $error("coefficient store not cleared by reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res9[0]) && $stable(res9[3]))
    else $error("stalled result changed inside the pipeline");

endmodule
